// ===== src/lpcd_pkg.sv =====
package lpcd_pkg;

  // Phase codes of the transaction tracker.
  localparam logic [4:0] PH_START    = 5'd0;
  localparam logic [4:0] PH_CYCTYPE  = 5'd1;
  localparam logic [4:0] PH_IOR_ADDR = 5'd2;
  localparam logic [4:0] PH_IOR_TAR  = 5'd3;
  localparam logic [4:0] PH_IOR_SYNC = 5'd4;
  localparam logic [4:0] PH_IOR_DATA = 5'd5;
  localparam logic [4:0] PH_IOW_ADDR = 5'd6;
  localparam logic [4:0] PH_IOW_DATA = 5'd7;
  localparam logic [4:0] PH_IOW_TAR  = 5'd8;
  localparam logic [4:0] PH_IOW_SYNC = 5'd9;
  localparam logic [4:0] PH_MW_ADDR  = 5'd10;
  localparam logic [4:0] PH_MW_DATA  = 5'd11;
  localparam logic [4:0] PH_MW_TAR   = 5'd12;
  localparam logic [4:0] PH_MW_SYNC  = 5'd13;
  localparam logic [4:0] PH_MR_ADDR  = 5'd14;
  localparam logic [4:0] PH_MR_TAR   = 5'd15;
  localparam logic [4:0] PH_MR_SYNC  = 5'd16;
  localparam logic [4:0] PH_MR_DATA  = 5'd17;
  localparam logic [4:0] PH_END_TAR  = 5'd18;

  // Cycle type codes, with bit 0 masked off.
  localparam logic [3:0] CYC_MASK      = 4'b1110;
  localparam logic [3:0] CYC_IO_READ   = 4'b0000;
  localparam logic [3:0] CYC_IO_WRITE  = 4'b0010;
  localparam logic [3:0] CYC_MEM_READ  = 4'b0100;
  localparam logic [3:0] CYC_MEM_WRITE = 4'b0110;

  // Nibble counts at which multi-clock phases end.
  localparam logic [2:0] HOLD_MEM_ADDR = 3'd7;
  localparam logic [2:0] HOLD_IO_ADDR  = 3'd3;
  localparam logic [2:0] HOLD_TWO      = 3'd1;

  localparam logic [7:0] SYNC_WAITS_MAX   = 8'hFF;
  localparam logic [7:0] MAX_SYNC_RESET   = 8'd16;

  typedef struct packed {
    logic [4:0] phase;
    logic [2:0] count;
    logic [7:0] waits;
  } state_t;

  typedef struct packed {
    logic [4:0] phase;
    logic [3:0] nibble;
    logic       sync_err;
    logic       frame_err;
    logic       last;
  } result_t;

endpackage

// ===== src/lpcd_in_if.sv =====
interface lpcd_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] lad;
  logic       frame_low;

  modport source (output valid, output lad, output frame_low, input ready);
  modport sink (input valid, input lad, input frame_low, output ready);
endinterface

// ===== src/lpcd_out_if.sv =====
interface lpcd_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] phase;
  logic [3:0] nibble;
  logic       sync_err;
  logic       frame_err;
  logic       last;

  modport source (output valid, output phase, output nibble, output sync_err,
                  output frame_err, output last, input ready);
  modport sink (input valid, input phase, input nibble, input sync_err,
                input frame_err, input last, output ready);
endinterface

// ===== src/lpcd_step.sv =====
module lpcd_step (
  input  lpcd_pkg::state_t  st,
  input  logic [3:0]        nibble,
  input  logic              frame_low,
  input  logic [7:0]        max_sync_waits,
  output lpcd_pkg::state_t  st_next,
  output logic              has_result,
  output lpcd_pkg::result_t res
);
  import lpcd_pkg::*;

  // Stay in the phase until the count reaches fin, then move to nxt.
  function automatic state_t hold_then(state_t s, logic [2:0] fin, logic [4:0] nxt);
    state_t r;
    r = s;
    if (s.count >= fin) begin
      r.phase = nxt;
      r.count = 3'd0;
    end else begin
      r.count = s.count + 3'd1;
    end
    return r;
  endfunction

  logic [4:0] ph;
  logic [7:0] waits_inc;
  logic       sync_hit;
  logic       serr;
  logic       ferr;
  logic       last;
  state_t     st_step;

  // Saturating wait count and limit check for sync phases.
  assign waits_inc = (st.waits == SYNC_WAITS_MAX) ? st.waits : st.waits + 8'd1;
  assign sync_hit  = (waits_inc >= max_sync_waits);

  // Out-of-range phases behave as idle.
  assign ph = (st.phase > PH_END_TAR) ? PH_START : st.phase;

  // One step of the transaction tracker.
  always_comb begin
    st_step    = st;
    serr       = 1'b0;
    ferr       = 1'b0;
    last       = 1'b0;
    has_result = 1'b1;
    if (ph == PH_START) begin
      st_step = '0;
      if (frame_low && nibble == 4'd0) begin
        st_step.phase = PH_CYCTYPE;
      end else begin
        has_result = 1'b0;
      end
    end else if (frame_low) begin
      ferr = 1'b1;
      last = 1'b1;
    end else begin
      case (ph)
        PH_CYCTYPE: begin
          st_step.count = 3'd0;
          case (nibble & CYC_MASK)
            CYC_IO_READ:   st_step.phase = PH_IOR_ADDR;
            CYC_IO_WRITE:  st_step.phase = PH_IOW_ADDR;
            CYC_MEM_READ:  st_step.phase = PH_MR_ADDR;
            CYC_MEM_WRITE: st_step.phase = PH_MW_ADDR;
            default:       last = 1'b1;
          endcase
        end
        PH_IOR_ADDR: st_step = hold_then(st, HOLD_IO_ADDR, PH_IOR_TAR);
        PH_IOR_TAR:  st_step = hold_then(st, HOLD_TWO, PH_IOR_SYNC);
        PH_IOR_DATA: st_step = hold_then(st, HOLD_TWO, PH_END_TAR);
        PH_IOW_ADDR: st_step = hold_then(st, HOLD_IO_ADDR, PH_IOW_DATA);
        PH_IOW_DATA: st_step = hold_then(st, HOLD_TWO, PH_IOW_TAR);
        PH_IOW_TAR:  st_step = hold_then(st, HOLD_TWO, PH_IOW_SYNC);
        PH_MW_ADDR:  st_step = hold_then(st, HOLD_MEM_ADDR, PH_MW_DATA);
        PH_MW_DATA:  st_step = hold_then(st, HOLD_TWO, PH_MW_TAR);
        PH_MW_TAR:   st_step = hold_then(st, HOLD_TWO, PH_MW_SYNC);
        PH_MR_ADDR:  st_step = hold_then(st, HOLD_MEM_ADDR, PH_MR_TAR);
        PH_MR_TAR:   st_step = hold_then(st, HOLD_TWO, PH_MR_SYNC);
        PH_MR_DATA:  st_step = hold_then(st, HOLD_TWO, PH_END_TAR);
        PH_IOR_SYNC, PH_IOW_SYNC, PH_MW_SYNC, PH_MR_SYNC: begin
          if (nibble == 4'd0) begin
            st_step.count = 3'd0;
            if (ph == PH_IOR_SYNC) begin
              st_step.phase = PH_IOR_DATA;
            end else if (ph == PH_MR_SYNC) begin
              st_step.phase = PH_MR_DATA;
            end else begin
              st_step.phase = PH_END_TAR;
            end
          end else begin
            st_step.waits = waits_inc;
            serr          = sync_hit;
            last          = sync_hit;
          end
        end
        default: begin
          // Final turnaround closes the transaction once its count is set.
          if (st.count >= 3'd1) begin
            last = 1'b1;
          end else begin
            st_step.count = 3'd1;
          end
        end
      endcase
    end
    st_next = last ? state_t'('0) : st_step;
  end

  assign res.phase     = ph;
  assign res.nibble    = nibble;
  assign res.sync_err  = serr;
  assign res.frame_err = ferr;
  assign res.last      = last;

endmodule

// ===== src/lpc_bus_cycle_decoder_top.sv =====
// LPC bus cycle decoder.
//
// The in_ch channel carries one LAD nibble and the LFRAME strobe per bus
// clock; the out_ch channel returns one result per clock of a transaction,
// tagged with the phase the tracker was in, error flags and a last flag.
// Idle clocks without a start (strobe asserted with nibble 0) give no result.
// The user must write the sync wait limit through cfg_write/cfg_data only while idle; the block does not enforce it.
//
// Each result is held first in the input register, then in the output register.
// Throughput: one item per cycle while out_ch keeps up; the tracker state
// register is updated by a single combinational step as each item moves
// from the input register to the output register.
//
// Reset (rst, synchronous) clears both registers' valid flags, returns the
// tracker to idle and loads a sync limit of 16.
// When out_ch stalls, the held result stays put, one further item waits in
// the input register and in_ch then drops ready until the result is taken.
module lpc_bus_cycle_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  lpcd_in_if.sink    in_ch,
  lpcd_out_if.source out_ch
);
  import lpcd_pkg::*;

  logic       s1_valid;
  logic [3:0] s1_nibble;
  logic       s1_frame;
  logic       out_valid;
  result_t    out_res;
  logic [7:0] max_sync_waits;
  state_t     st;
  state_t     st_next;
  logic       has_result;
  result_t    res;
  logic       out_free;
  logic       s1_fire;

  // Handshake glue between the two register stages.
  assign out_free    = !out_valid || out_ch.ready;
  assign s1_fire     = s1_valid && out_free;
  assign in_ch.ready = !s1_valid || s1_fire;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_sync_waits <= MAX_SYNC_RESET;
    end else if (cfg_write) begin
      max_sync_waits <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_nibble <= in_ch.lad;
      s1_frame  <= in_ch.frame_low;
    end
  end

  lpcd_step u_step (
    .st             (st),
    .nibble         (s1_nibble),
    .frame_low      (s1_frame),
    .max_sync_waits (max_sync_waits),
    .st_next        (st_next),
    .has_result     (has_result),
    .res            (res)
  );

  // Tracker state advances with each item leaving the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (s1_fire) begin
      st <= st_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_fire && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && has_result) begin
      out_res <= res;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.phase     = out_res.phase;
  assign out_ch.nibble    = out_res.nibble;
  assign out_ch.sync_err  = out_res.sync_err;
  assign out_ch.frame_err = out_res.frame_err;
  assign out_ch.last      = out_res.last;

  // A sync error always closes the transaction.
  a_serr_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.sync_err |-> out_res.last)
    else $error("sync error without last");

  // Both error kinds never appear together.
  a_err_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.sync_err && out_res.frame_err))
    else $error("sync and frame error together");

  // A closing result leaves the tracker idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    s1_fire && has_result && res.last |=> st.phase == PH_START)
    else $error("tracker not idle after last");

  // While idle the counters are clear.
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_START |-> st.count == 3'd0 && st.waits == 8'd0)
    else $error("counters not clear while idle");

  // Reported phases stay within the defined range.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_res.phase <= PH_END_TAR)
    else $error("phase out of range");

endmodule

// ===== bench/testbench.sv =====
module testbench;
  import lpcd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_GAP   = 4;
  localparam int LONG_STALL  = 60;

  // One bus clock as offered on the input channel.
  typedef struct packed {
    logic [3:0] nibble;
    logic       frame;
  } bus_clock_t;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [7:0] cfg_data;

  lpcd_in_if  in_ch ();
  lpcd_out_if out_ch ();

  lpc_bus_cycle_decoder_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Stimulus side bookkeeping.
  bus_clock_t pending_clocks[$];
  int         items_queued = 0;
  int         items_accepted = 0;
  bit         took_item = 1'b0;
  bit         hold_send = 1'b0;
  bit         long_stall_req = 1'b0;
  int         stall_left = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  logic [7:0] limit_setting = MAX_SYNC_RESET;

  // Transaction tracker mirror and the results it still owes.
  logic [4:0] trk_phase;
  logic [2:0] trk_count;
  logic [7:0] trk_waits;
  logic [7:0] trk_limit;
  result_t    decoded_clocks[$];
  int         mismatches = 0;
  int         cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stay in a multi-clock phase until its last clock, then move on.
  function automatic void hold_phase(input logic [2:0] final_count, input logic [4:0] next);
    if (trk_count >= final_count) begin
      trk_phase = next;
      trk_count = 3'd0;
    end else begin
      trk_count = trk_count + 3'd1;
    end
  endfunction

  // Sync phase: a zero nibble moves on, anything else counts as a wait.
  function automatic bit sync_phase(input logic [3:0] nib, input logic [4:0] next);
    if (nib == 4'd0) begin
      trk_phase = next;
      trk_count = 3'd0;
      return 1'b0;
    end
    if (trk_waits < SYNC_WAITS_MAX) trk_waits = trk_waits + 8'd1;
    return trk_waits >= trk_limit;
  endfunction

  // Advance the tracker by one bus clock; returns 1 when the clock yields a result.
  function automatic bit track_clock(input logic [3:0] nib, input logic fl,
                                     output result_t res);
    logic [4:0] ph;
    bit         serr;
    bit         ferr;
    bit         done;
    ph = trk_phase;
    serr = 1'b0;
    ferr = 1'b0;
    done = 1'b0;
    res = '0;
    if (ph > PH_END_TAR) begin
      ph = PH_START;
      trk_phase = PH_START;
      trk_count = 3'd0;
      trk_waits = 8'd0;
    end
    if (ph == PH_START) begin
      if (!(fl && nib == 4'd0)) return 1'b0;
      trk_phase = PH_CYCTYPE;
      trk_count = 3'd0;
      trk_waits = 8'd0;
    end else if (fl) begin
      ferr = 1'b1;
      done = 1'b1;
    end else begin
      case (ph)
        PH_CYCTYPE: begin
          trk_count = 3'd0;
          case (nib & CYC_MASK)
            CYC_IO_READ:   trk_phase = PH_IOR_ADDR;
            CYC_IO_WRITE:  trk_phase = PH_IOW_ADDR;
            CYC_MEM_READ:  trk_phase = PH_MR_ADDR;
            CYC_MEM_WRITE: trk_phase = PH_MW_ADDR;
            default:       done = 1'b1;
          endcase
        end
        PH_IOR_ADDR: hold_phase(HOLD_IO_ADDR, PH_IOR_TAR);
        PH_IOR_TAR:  hold_phase(HOLD_TWO, PH_IOR_SYNC);
        PH_IOR_SYNC: serr = sync_phase(nib, PH_IOR_DATA);
        PH_IOR_DATA: hold_phase(HOLD_TWO, PH_END_TAR);
        PH_IOW_ADDR: hold_phase(HOLD_IO_ADDR, PH_IOW_DATA);
        PH_IOW_DATA: hold_phase(HOLD_TWO, PH_IOW_TAR);
        PH_IOW_TAR:  hold_phase(HOLD_TWO, PH_IOW_SYNC);
        PH_IOW_SYNC: serr = sync_phase(nib, PH_END_TAR);
        PH_MW_ADDR:  hold_phase(HOLD_MEM_ADDR, PH_MW_DATA);
        PH_MW_DATA:  hold_phase(HOLD_TWO, PH_MW_TAR);
        PH_MW_TAR:   hold_phase(HOLD_TWO, PH_MW_SYNC);
        PH_MW_SYNC:  serr = sync_phase(nib, PH_END_TAR);
        PH_MR_ADDR:  hold_phase(HOLD_MEM_ADDR, PH_MR_TAR);
        PH_MR_TAR:   hold_phase(HOLD_TWO, PH_MR_SYNC);
        PH_MR_SYNC:  serr = sync_phase(nib, PH_MR_DATA);
        PH_MR_DATA:  hold_phase(HOLD_TWO, PH_END_TAR);
        default: begin
          // Final turnaround closes the transaction once its count is set.
          if (trk_count >= HOLD_TWO) done = 1'b1;
          else trk_count = HOLD_TWO;
        end
      endcase
      if (serr) done = 1'b1;
    end
    if (done) begin
      trk_phase = PH_START;
      trk_count = 3'd0;
      trk_waits = 8'd0;
    end
    res.phase = ph;
    res.nibble = nib;
    res.sync_err = serr;
    res.frame_err = ferr;
    res.last = done;
    return 1'b1;
  endfunction

  // Driver: offers the next pending bus clock once the previous transfer is done.
  always @(negedge clk) begin
    bus_clock_t cur;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || took_item) begin
      took_item = 1'b0;
      if (pending_clocks.size() != 0 && !hold_send &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        cur = pending_clocks.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.lad <= cur.nibble;
        in_ch.frame_low <= cur.frame;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink: random back-pressure plus an occasional long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (long_stall_req) begin
      long_stall_req = 1'b0;
      stall_left = LONG_STALL;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: checks each result transfer, then predicts from each input transfer.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    result_t predicted;
    if (rst) begin
      trk_phase = PH_START;
      trk_count = 3'd0;
      trk_waits = 8'd0;
      trk_limit = MAX_SYNC_RESET;
      decoded_clocks.delete();
    end else begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("%0t: timeout with %0d results outstanding", $time, decoded_clocks.size());
        $display("testbench NOT OK");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.phase = out_ch.phase;
        got.nibble = out_ch.nibble;
        got.sync_err = out_ch.sync_err;
        got.frame_err = out_ch.frame_err;
        got.last = out_ch.last;
        if (decoded_clocks.size() == 0) begin
          mismatches = mismatches + 1;
          $display({"%0t: unexpected result: expected none, got phase %0d nibble %h ",
                    "serr %b ferr %b last %b"},
                   $time, got.phase, got.nibble, got.sync_err, got.frame_err,
                   got.last);
        end else begin
          want = decoded_clocks.pop_front();
          if (got.phase !== want.phase || got.nibble !== want.nibble ||
              got.sync_err !== want.sync_err || got.frame_err !== want.frame_err ||
              got.last !== want.last) begin
            mismatches = mismatches + 1;
            $display({"%0t: result mismatch: expected phase %0d nibble %h serr %b ",
                      "ferr %b last %b, got phase %0d nibble %h serr %b ferr %b last %b"},
                     $time, want.phase, want.nibble, want.sync_err, want.frame_err,
                     want.last, got.phase, got.nibble, got.sync_err, got.frame_err,
                     got.last);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        took_item = 1'b1;
        items_accepted = items_accepted + 1;
        if (track_clock(in_ch.lad, in_ch.frame_low, predicted))
          decoded_clocks.insert(decoded_clocks.size(), predicted);
      end
      if (cfg_write) trk_limit = cfg_data;
    end
  end

  task automatic queue_bus_clock(input bus_clock_t item);
    pending_clocks.insert(pending_clocks.size(), item);
    items_queued = items_queued + 1;
  endtask

  // Queue one transaction; sync waits stop at the limit, and a strobe at
  // position abort_at (when positive) cuts the transaction short.
  task automatic queue_cycle(input logic [3:0] cyc, input int waits, input int abort_at);
    bus_clock_t seq[$];
    int         pre_len;
    int         post_len;
    int         held;
    seq.insert(seq.size(), {4'h0, 1'b1});
    seq.insert(seq.size(), {cyc, 1'b0});
    case (cyc & CYC_MASK)
      CYC_IO_READ: begin
        pre_len = 6;
        post_len = 4;
      end
      CYC_IO_WRITE: begin
        pre_len = 8;
        post_len = 2;
      end
      CYC_MEM_READ: begin
        pre_len = 10;
        post_len = 4;
      end
      CYC_MEM_WRITE: begin
        pre_len = 12;
        post_len = 2;
      end
      default: begin
        pre_len = -1;
        post_len = 0;
      end
    endcase
    if (pre_len >= 0) begin
      repeat (pre_len) seq.insert(seq.size(), {4'($urandom_range(0, 15)), 1'b0});
      held = (waits < limit_setting) ? waits : limit_setting;
      repeat (held) seq.insert(seq.size(), {4'($urandom_range(1, 15)), 1'b0});
      if (waits < limit_setting) begin
        seq.insert(seq.size(), {4'h0, 1'b0});
        repeat (post_len) seq.insert(seq.size(), {4'($urandom_range(0, 15)), 1'b0});
      end
    end
    if (abort_at > 0 && abort_at < seq.size()) begin
      while (seq.size() > abort_at) void'(seq.pop_back());
      seq.insert(seq.size(),
                 {($urandom_range(0, 1) ? 4'h0 : 4'($urandom_range(0, 15))), 1'b1});
    end
    foreach (seq[i]) queue_bus_clock(seq[i]);
  endtask

  // Random traffic: mostly well-formed transactions, with idle noise between
  // them, some unsupported cycle types, sync timeouts and strobe aborts.
  task automatic queue_random_cycles(input int count);
    int         target;
    int         roll;
    int         waits;
    int         abort_at;
    logic [3:0] cyc;
    bus_clock_t noise;
    target = items_queued + count;
    while (items_queued < target) begin
      repeat ($urandom_range(0, 2)) begin
        noise = {4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))};
        if (noise.frame && noise.nibble == 4'h0) noise.nibble = 4'($urandom_range(1, 15));
        queue_bus_clock(noise);
      end
      roll = $urandom_range(0, 19);
      case (roll % 4)
        0: cyc = CYC_IO_READ;
        1: cyc = CYC_IO_WRITE;
        2: cyc = CYC_MEM_READ;
        default: cyc = CYC_MEM_WRITE;
      endcase
      cyc[0] = 1'($urandom_range(0, 1));
      if (roll == 0) cyc = 4'($urandom_range(8, 15));
      roll = $urandom_range(0, 9);
      if (roll < 7) waits = $urandom_range(0, 2);
      else if (roll < 9) waits = $urandom_range(3, 6);
      else if (limit_setting <= 8) waits = limit_setting + $urandom_range(0, 1);
      else waits = $urandom_range(3, 8);
      abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : -1;
      queue_cycle(cyc, waits, abort_at);
    end
  endtask

  // Wait until every queued clock is taken and every result is back, then
  // give a no-result clock still inside the block time to clear.
  task automatic wait_for_drain();
    do @(negedge clk);
    while (!(items_accepted == items_queued && decoded_clocks.size() == 0));
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic set_sync_limit(input logic [7:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    limit_setting = value;
  endtask

  // Main sequence.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.lad = 4'h0;
    in_ch.frame_low = 1'b0;
    out_ch.ready = 1'b0;
    cfg_write = 1'b0;
    cfg_data = 8'h00;
    rst = 1'b1;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Sender idles lightly, receiver heavily.
    send_idle_pct = 17;
    recv_idle_pct = 50;

    // Directed: clocks ignored while idle, unsupported cycle types, a strobe
    // at the cycle type clock, a full I/O read with a wait, and a strobe
    // arriving during a sync phase.
    queue_bus_clock({4'h5, 1'b0});
    queue_bus_clock({4'h0, 1'b0});
    queue_bus_clock({4'hF, 1'b1});
    queue_cycle(4'hF, 0, -1);
    queue_cycle(4'h8, 0, -1);
    queue_bus_clock({4'h0, 1'b1});
    queue_bus_clock({4'h0, 1'b1});
    queue_cycle(CYC_IO_READ | 4'h1, 1, -1);
    queue_cycle(CYC_MEM_WRITE, 2, 15);
    queue_random_cycles(120);

    // Hold the receiver off while the sender keeps offering.
    @(posedge clk);
    long_stall_req = 1'b1;
    wait_for_drain();

    // Limit of one: any wait is a sync error.
    set_sync_limit(8'd1);
    queue_random_cycles(120);
    wait_for_drain();

    // Sender idles heavily, receiver lightly; largest limit first.
    send_idle_pct = 50;
    recv_idle_pct = 17;
    set_sync_limit(8'd255);
    queue_cycle(CYC_MEM_READ, 300, -1);
    queue_random_cycles(100);
    wait_for_drain();

    set_sync_limit(8'($urandom_range(2, 8)));
    queue_random_cycles(150);
    // Pause the sender midway until every owed result has arrived.
    do @(posedge clk);
    while (pending_clocks.size() > 60);
    hold_send = 1'b1;
    do @(negedge clk);
    while (in_ch.valid || decoded_clocks.size() != 0);
    @(posedge clk);
    hold_send = 1'b0;
    wait_for_drain();

    // No idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_sync_limit(8'($urandom_range(1, 20)));
    queue_random_cycles(200);
    wait_for_drain();

    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/lpcd_pkg.sv
src/lpcd_in_if.sv
src/lpcd_out_if.sv
src/lpcd_step.sv
src/lpc_bus_cycle_decoder_top.sv
bench/testbench.sv
